// File: rtl/core/dpir_pkg.sv
// Package for the DMA priority and interrupt registers: types, constants and the summary function.
`default_nettype none

package dpir_pkg;

   localparam int unsigned DPIR_NUM_CHANNELS = 7;
   localparam int unsigned CHAN_W = 3;

   localparam logic [31:0] CTRL_RESET = 32'h0765_4321;
   localparam logic [31:0] IEN_MASK   = 32'h007F_0000;
   localparam logic [31:0] IFLAG_MASK = 32'h7F00_0000;

   localparam int unsigned IEN_LSB    = 16;
   localparam int unsigned IFLAG_LSB  = 24;
   localparam int unsigned FORCE_BIT  = 15;
   localparam int unsigned MASTER_BIT = 23;
   localparam int unsigned SUM_BIT    = 31;

   localparam int unsigned NIB_W      = 4;
   localparam int unsigned PRI_W      = 3;
   localparam int unsigned RUN_BIT    = 3;

   localparam logic [2:0] SEL_CLEAR_BYTE = 3'd7;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_TICK = 1'b1
   } state_type;

   function automatic logic summary_bit(input logic [31:0] w);
      logic [31:0] en_fl;
      begin
         en_fl = ((w & IEN_MASK) << (IFLAG_LSB - IEN_LSB)) & (w & IFLAG_MASK);
         summary_bit = w[FORCE_BIT] | (w[MASTER_BIT] & (en_fl != 32'd0));
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/dma_priority_interrupt_regs.sv
// DMA controller control and interrupt registers with a priority-ordered channel sequencer.
// Reads, writes and unused ops: one result, registered in the cycle after the transfer;
//    with a free output and no tick running one such access is accepted every cycle.
// Tick: NUM_CHANNELS results, one per cycle while the output is free, from a shared 7-way
//    priority search picking the next unserved channel; requests stall until the tick ends.
// Synchronous active-high reset: control word 0x07654321, interrupt word zero, output empty.
`default_nettype none

module dma_priority_interrupt_regs
   import dpir_pkg::*;
#(
   parameter int unsigned NUM_CHANNELS = DPIR_NUM_CHANNELS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic [1:0]              req_op,
   input  wire logic [2:0]              req_byte_sel,
   input  wire logic [7:0]              req_wdata,
   input  wire logic [6:0]              req_req_mask,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic [7:0]                   rsp_rdata,
   output logic [CHAN_W-1:0]            rsp_chan,
   output logic                         rsp_chan_run,
   output logic                         rsp_irq,
   output logic                         rsp_last
);

   state_type                state_ff, state_in;
   logic [31:0]              ctrl_ff, ctrl_in;
   logic [31:0]              intr_ff, intr_in;
   logic [NUM_CHANNELS-1:0]  done_ff, done_in;
   logic                     any_ff, any_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_rdata_ff, rsp_rdata_in;
   logic [CHAN_W-1:0]        rsp_chan_ff, rsp_chan_in;
   logic                     rsp_run_ff, rsp_run_in;
   logic                     rsp_irq_ff, rsp_irq_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     out_free;
   logic                     sel_found;
   logic [PRI_W-1:0]         sel_pri;
   logic [CHAN_W-1:0]        sel_ch;
   logic                     sel_run;
   logic [NUM_CHANNELS-1:0]  sel_onehot;
   logic [NUM_CHANNELS-1:0]  done_next;
   logic [31:0]              word_v;
   logic                     any_v;
   logic [4:0]               shift_v;

   // The shared priority search: ascending scan with >= favors the higher channel on a tie.
   always_comb begin
      sel_found  = 1'b0;
      sel_pri    = '0;
      sel_ch     = '0;
      sel_run    = 1'b0;
      sel_onehot = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         if (!done_ff[c] && (!sel_found || ctrl_ff[NIB_W*c +: PRI_W] >= sel_pri)) begin
            sel_found     = 1'b1;
            sel_pri       = ctrl_ff[NIB_W*c +: PRI_W];
            sel_ch        = CHAN_W'(c);
            sel_run       = ctrl_ff[NIB_W*c + RUN_BIT];
            sel_onehot    = '0;
            sel_onehot[c] = 1'b1;
         end
      end
   end

   assign done_next = done_ff | sel_onehot;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;

   always_comb begin
      state_in     = state_ff;
      ctrl_in      = ctrl_ff;
      intr_in      = intr_ff;
      done_in      = done_ff;
      any_in       = any_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_chan_in  = rsp_chan_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_irq_in   = rsp_irq_ff;
      rsp_last_in  = rsp_last_ff;
      word_v       = intr_ff;
      any_v        = 1'b0;
      shift_v      = {req_byte_sel[1:0], 3'b000};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               rsp_valid_in = 1'b1;
               rsp_rdata_in = '0;
               rsp_chan_in  = '0;
               rsp_run_in   = 1'b0;
               rsp_irq_in   = 1'b0;
               rsp_last_in  = 1'b1;
               unique case (op_type'(req_op))
                  OP_READ: begin
                     if (req_byte_sel[2]) begin
                        rsp_rdata_in = intr_ff[shift_v +: 8];
                     end else begin
                        rsp_rdata_in = ctrl_ff[shift_v +: 8];
                     end
                  end
                  OP_WRITE: begin
                     if (!req_byte_sel[2]) begin
                        ctrl_in[shift_v +: 8] = req_wdata;
                     end else begin
                        if (req_byte_sel == SEL_CLEAR_BYTE) begin
                           word_v[31:24] = intr_ff[31:24] & ~req_wdata;
                        end else begin
                           word_v[shift_v +: 8] = req_wdata;
                        end
                        word_v[SUM_BIT] = summary_bit(word_v);
                        intr_in = word_v;
                     end
                  end
                  OP_TICK: begin
                     for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (req_req_mask[c] && intr_ff[IEN_LSB + c]) begin
                           word_v[IFLAG_LSB + c] = 1'b1;
                           any_v = 1'b1;
                        end
                     end
                     intr_in      = word_v;
                     any_in       = any_v;
                     done_in      = '0;
                     rsp_valid_in = 1'b0;
                     state_in     = ST_TICK;
                  end
                  OP_NONE: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_rdata_in = '0;
               rsp_chan_in  = sel_ch;
               rsp_run_in   = sel_run;
               rsp_last_in  = (done_next == '1);
               rsp_irq_in   = (done_next == '1) && any_ff &&
                              (intr_ff[FORCE_BIT] || intr_ff[MASTER_BIT]);
               done_in      = done_next;
               if (done_next == '1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctrl_ff      <= CTRL_RESET;
         intr_ff      <= '0;
         done_ff      <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl_ff      <= ctrl_in;
         intr_ff      <= intr_in;
         done_ff      <= done_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_irq_ff   <= rsp_irq_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rdata    = rsp_rdata_ff;
   assign rsp_chan     = rsp_chan_ff;
   assign rsp_chan_run = rsp_run_ff;
   assign rsp_irq      = rsp_irq_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

`default_nettype wire
